// ===== sv/vpt_pkg.sv =====
// Shared types and constants for the vertex projection transform.
// Used by every module of the block; depends on nothing.
package vpt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int IDX_W     = 3;
    localparam int SUM_W     = 66;
    localparam int MAG_W     = 64;
    localparam int REM_W     = 96;
    localparam int QBITS     = 32;

    localparam logic OP_AFFINE = 1'b0;
    localparam logic OP_PROJ   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_WZERO = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
    } out_t;

    // Exact row sums, rows 0..2 affine, row 3 gives w.
    typedef struct packed {
        logic                  op;
        logic [3:0][SUM_W-1:0] sum;
    } qent_t;

endpackage

// ===== sv/vertex_projection_transform.sv =====
// Top level of the homogeneous 4x4 vertex transform.
// Depends on vpt_pkg, vpt_front, vpt_queue and vpt_back.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one point and an op per item,
//     op 0 affine, op 1 projective with divide by w.
//   out channel (out_valid/out_ready/out_data): one result item per point,
//     in order, with a status of ok, saturated or w zero.
//   cfg port (cfg_we/cfg_index/cfg_data): writes one 64-bit register holding
//     two matrix elements; write only while no item is in flight.
// Throughput: one item per cycle for both ops, sustained while out_ready stays high.
// Pipeline, in order from input accept to output valid:
//   two front stages (products, row sums), one queue slot, a magnitude
//   stage, a setup stage, 32 divide stages (one quotient bit each) and the
//   output register. Affine items flow through the same stages.
// Reset: clears all valid state and loads the identity matrix.
// Stall: when out_ready is low the back end holds; the four-entry queue then
//   absorbs the front end's items until it fills and in_ready drops.
module vertex_projection_transform (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  vpt_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output vpt_pkg::out_t             out_data,
    input  logic                      cfg_we,
    input  logic [vpt_pkg::IDX_W-1:0] cfg_index,
    input  logic [vpt_pkg::REG_W-1:0] cfg_data
);

    logic           fq_valid;
    logic           fq_ready;
    vpt_pkg::qent_t fq_data;
    logic           qb_valid;
    logic           qb_ready;
    vpt_pkg::qent_t qb_data;

    vpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    vpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    vpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sv/vpt_front.sv =====
// Front end: matrix registers, input handshake, products and row sums.
// Depends on vpt_pkg; feeds the queue.
module vpt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vpt_pkg::in_t                  in_data,
    input  logic                          cfg_we,
    input  logic [vpt_pkg::IDX_W-1:0]     cfg_index,
    input  logic [vpt_pkg::REG_W-1:0]     cfg_data,
    output logic                          q_valid,
    input  logic                          q_ready,
    output vpt_pkg::qent_t                q_data
);

    localparam logic [vpt_pkg::REG_W-1:0] ONE_LO =
        vpt_pkg::REG_W'(1) << vpt_pkg::FRAC_BITS;
    localparam logic [vpt_pkg::REG_W-1:0] ONE_HI = ONE_LO << 32;

    logic [vpt_pkg::REG_W-1:0]   mat_reg [vpt_pkg::NUM_REGS];
    logic signed [31:0]          m [16];
    logic signed [31:0]          pt [3];

    logic                        v1_reg;
    logic                        op1_reg;
    logic signed [63:0]          prod_reg [4][3];
    logic signed [31:0]          trans_reg [4];

    logic signed [vpt_pkg::SUM_W-1:0] sum_c [4];

    logic                        v2_reg;
    vpt_pkg::qent_t              q_reg;
    logic                        en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Identity matrix: ones on the diagonal.
            for (int i = 0; i < vpt_pkg::NUM_REGS; i++)
            begin
                if (i == 0 || i == 5)
                begin
                    mat_reg[i] <= ONE_LO;
                end
                else if (i == 2 || i == 7)
                begin
                    mat_reg[i] <= ONE_HI;
                end
                else
                begin
                    mat_reg[i] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            m[i] = mat_reg[i / 2][(i % 2) * 32 +: 32];
        end
        pt[0] = in_data.in_x;
        pt[1] = in_data.in_y;
        pt[2] = in_data.in_z;
    end

    // Advance the whole front together; hold when the queue is full.
    assign en       = !v2_reg || q_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= in_data.op;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= m[r + 4 * c] * pt[c];
                end
                trans_reg[r] <= m[r + 12];
            end
            q_reg.op <= op1_reg;
            for (int r = 0; r < 4; r++)
            begin
                q_reg.sum[r] <= sum_c[r];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_c[r] = vpt_pkg::SUM_W'(prod_reg[r][0]) + vpt_pkg::SUM_W'(prod_reg[r][1])
                     + vpt_pkg::SUM_W'(prod_reg[r][2])
                     + (vpt_pkg::SUM_W'(trans_reg[r]) <<< vpt_pkg::FRAC_BITS);
        end
    end

    assign q_valid = v2_reg;
    assign q_data  = q_reg;

endmodule

// ===== sv/vpt_queue.sv =====
// Short queue of row sums between front and back end.
// Depends on vpt_pkg for the entry type.
module vpt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  vpt_pkg::qent_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output vpt_pkg::qent_t rd_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    vpt_pkg::qent_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != (PTR_W + 1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/vpt_back.sv =====
// Back end: magnitudes, pipelined restoring divide by w, saturation, output register.
// Depends on vpt_pkg; reads from the queue.
module vpt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  vpt_pkg::qent_t q_data,
    output logic           out_valid,
    input  logic           out_ready,
    output vpt_pkg::out_t  out_data
);

    typedef struct packed {
        logic                               op;
        logic                               zw;
        logic [vpt_pkg::MAG_W-1:0]          d;
        logic [2:0]                         neg;
        logic [2:0]                         sat;
        logic [2:0][31:0]                   res;
        logic [2:0][vpt_pkg::REM_W-1:0]     rem;
    } dv_t;

    function automatic logic [32:0] pack32(input logic [vpt_pkg::MAG_W-1:0] v,
                                           input logic neg);
        logic [31:0] nv;
        nv = 32'd0 - v[31:0];
        if (!neg && v > vpt_pkg::MAG_W'(32'h7FFF_FFFF))
        begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        else if (neg && v > vpt_pkg::MAG_W'(32'h8000_0000))
        begin
            return {1'b1, 32'h8000_0000};
        end
        else
        begin
            return {1'b0, neg ? nv : v[31:0]};
        end
    endfunction

    logic                            en;
    logic                            a_v_reg;
    logic                            a_op_reg;
    logic [3:0]                      a_neg_reg;
    logic [vpt_pkg::MAG_W-1:0]       a_mag_reg [4];

    dv_t                             dv_reg [vpt_pkg::QBITS+1];
    dv_t                             dv_nx  [vpt_pkg::QBITS+1];
    logic [vpt_pkg::QBITS:0]         dvv_reg;

    logic                            out_valid_reg;
    vpt_pkg::out_t                   out_reg;
    vpt_pkg::out_t                   out_nx;

    // Advance the whole back end together; hold while the output waits.
    assign en        = !out_valid_reg || out_ready;
    assign q_ready   = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg       <= 1'b0;
            dvv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg       <= q_valid;
            dvv_reg       <= {dvv_reg[vpt_pkg::QBITS-1:0], a_v_reg};
            out_valid_reg <= dvv_reg[vpt_pkg::QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [vpt_pkg::SUM_W-1:0] ns;
        if (en)
        begin
            a_op_reg <= q_data.op;
            for (int r = 0; r < 4; r++)
            begin
                ns = vpt_pkg::SUM_W'(0) - q_data.sum[r];
                a_neg_reg[r] <= q_data.sum[r][vpt_pkg::SUM_W-1];
                a_mag_reg[r] <= q_data.sum[r][vpt_pkg::SUM_W-1]
                                ? ns[vpt_pkg::MAG_W-1:0]
                                : q_data.sum[r][vpt_pkg::MAG_W-1:0];
            end
            for (int k = 0; k <= vpt_pkg::QBITS; k++)
            begin
                dv_reg[k] <= dv_nx[k];
            end
            out_reg <= out_nx;
        end
    end

    // Set up each row: pack affine results, or load the dividend and flag huge quotients.
    // Then one quotient bit per stage, most significant first.
    always_comb
    begin
        logic [32:0]               pk;
        logic [vpt_pkg::REM_W-1:0] num;
        logic [vpt_pkg::REM_W-1:0] lim;
        logic [vpt_pkg::REM_W-1:0] sh;
        dv_nx[0]     = '0;
        dv_nx[0].op  = a_op_reg;
        dv_nx[0].d   = a_mag_reg[3];
        dv_nx[0].zw  = (a_op_reg == vpt_pkg::OP_PROJ) && (a_mag_reg[3] == '0);
        lim          = vpt_pkg::REM_W'(a_mag_reg[3]) << vpt_pkg::QBITS;
        for (int r = 0; r < 3; r++)
        begin
            pk  = pack32(a_mag_reg[r] >> vpt_pkg::FRAC_BITS, a_neg_reg[r]);
            num = vpt_pkg::REM_W'(a_mag_reg[r]) << vpt_pkg::FRAC_BITS;
            if (a_op_reg == vpt_pkg::OP_AFFINE)
            begin
                dv_nx[0].res[r] = pk[31:0];
                dv_nx[0].sat[r] = pk[32];
                dv_nx[0].neg[r] = a_neg_reg[r];
            end
            else
            begin
                dv_nx[0].rem[r] = num;
                dv_nx[0].sat[r] = !dv_nx[0].zw && (num >= lim);
                dv_nx[0].neg[r] = a_neg_reg[r] ^ a_neg_reg[3];
            end
        end
        for (int k = 1; k <= vpt_pkg::QBITS; k++)
        begin
            dv_nx[k] = dv_reg[k-1];
            sh       = vpt_pkg::REM_W'(dv_reg[k-1].d) << (vpt_pkg::QBITS - k);
            for (int r = 0; r < 3; r++)
            begin
                if (dv_reg[k-1].op == vpt_pkg::OP_PROJ && dv_reg[k-1].rem[r] >= sh)
                begin
                    dv_nx[k].rem[r] = dv_reg[k-1].rem[r] - sh;
                    dv_nx[k].res[r][vpt_pkg::QBITS - k] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic [32:0] pk;
        logic [2:0]  rs;
        logic [31:0] rv [3];
        dv_t         f;
        f = dv_reg[vpt_pkg::QBITS];
        for (int r = 0; r < 3; r++)
        begin
            pk = pack32(vpt_pkg::MAG_W'(f.res[r]), f.neg[r]);
            if (f.op == vpt_pkg::OP_AFFINE)
            begin
                rv[r] = f.res[r];
                rs[r] = f.sat[r];
            end
            else if (f.zw)
            begin
                rv[r] = 32'd0;
                rs[r] = 1'b0;
            end
            else if (f.sat[r])
            begin
                rv[r] = f.neg[r] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                rs[r] = 1'b1;
            end
            else
            begin
                rv[r] = pk[31:0];
                rs[r] = pk[32];
            end
        end
        out_nx.out_x = rv[0];
        out_nx.out_y = rv[1];
        out_nx.out_z = rv[2];
        if (f.op == vpt_pkg::OP_PROJ && f.zw)
        begin
            out_nx.status = vpt_pkg::ST_WZERO;
        end
        else if (rs != 3'b000)
        begin
            out_nx.status = vpt_pkg::ST_SAT;
        end
        else
        begin
            out_nx.status = vpt_pkg::ST_OK;
        end
    end

endmodule

// ===== test/vertex_projection_transform_tb.sv =====
// Testbench for the homogeneous 4x4 vertex transform: random and directed points.
// Depends on vpt_pkg and vertex_projection_transform; a scoreboard class predicts results.
`timescale 1ns / 1ps

module vertex_projection_transform_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 50;

    class vertex_scoreboard;
        logic [vpt_pkg::REG_W-1:0] matrix [vpt_pkg::NUM_REGS];
        vpt_pkg::out_t pending [$];
        int mismatches;
        int checked;
        int sat_seen;
        int wzero_seen;

        function new();
            mismatches = 0;
            checked = 0;
            sat_seen = 0;
            wzero_seen = 0;
            for (int i = 0; i < vpt_pkg::NUM_REGS; i++)
                matrix[i] = '0;
            matrix[0] = 64'd1 << vpt_pkg::FRAC_BITS;
            matrix[2] = 64'd1 << (vpt_pkg::FRAC_BITS + 32);
            matrix[5] = 64'd1 << vpt_pkg::FRAC_BITS;
            matrix[7] = 64'd1 << (vpt_pkg::FRAC_BITS + 32);
        endfunction

        function void set_reg(int idx, logic [vpt_pkg::REG_W-1:0] val);
            matrix[idx] = val;
        endfunction

        function logic signed [31:0] element(int i);
            logic [vpt_pkg::REG_W-1:0] r;
            r = matrix[i >> 1];
            return (i & 1) ? $signed(r[63:32]) : $signed(r[31:0]);
        endfunction

        // Exact row sum: products at 2F fraction bits, translation shifted up by F.
        function logic signed [67:0] row_sum(int r, vpt_pkg::in_t d);
            logic signed [67:0] ex, ey, ez, et, px, py, pz;
            ex = element(r);
            ey = element(r + 4);
            ez = element(r + 8);
            et = element(r + 12);
            px = d.in_x;
            py = d.in_y;
            pz = d.in_z;
            return ex * px + ey * py + ez * pz + (et <<< vpt_pkg::FRAC_BITS);
        endfunction

        function logic [31:0] clamp(logic [95:0] m, bit neg, inout bit sat);
            logic [31:0] res;
            if (!neg && m > 96'h7FFF_FFFF) begin
                sat = 1;
                res = 32'h7FFF_FFFF;
            end else if (neg && m > 96'h8000_0000) begin
                sat = 1;
                res = 32'h8000_0000;
            end else begin
                res = neg ? 32'(-m) : m[31:0];
            end
            return res;
        endfunction

        function void note_point(vpt_pkg::in_t d);
            vpt_pkg::out_t e;
            logic signed [67:0] s, w;
            logic [95:0] mag, wmag, q;
            logic [31:0] o [3];
            bit sat, neg;
            sat = 0;
            if (d.op == vpt_pkg::OP_AFFINE) begin
                for (int r = 0; r < 3; r++) begin
                    s = row_sum(r, d);
                    mag = s < 0 ? 96'(-s) : 96'(s);
                    o[r] = clamp(mag >> vpt_pkg::FRAC_BITS, s < 0, sat);
                end
                e.status = sat ? vpt_pkg::ST_SAT : vpt_pkg::ST_OK;
            end else begin
                w = row_sum(3, d);
                wmag = w < 0 ? 96'(-w) : 96'(w);
                if (wmag == 0) begin
                    for (int r = 0; r < 3; r++)
                        o[r] = '0;
                    e.status = vpt_pkg::ST_WZERO;
                end else begin
                    for (int r = 0; r < 3; r++) begin
                        s = row_sum(r, d);
                        mag = s < 0 ? 96'(-s) : 96'(s);
                        q = (mag << vpt_pkg::FRAC_BITS) / wmag;
                        neg = ((s < 0) != (w < 0)) && q != 0;
                        o[r] = clamp(q, neg, sat);
                    end
                    e.status = sat ? vpt_pkg::ST_SAT : vpt_pkg::ST_OK;
                end
            end
            e.out_x = o[0];
            e.out_y = o[1];
            e.out_z = o[2];
            pending.push_back(e);
        endfunction

        function void check_result(vpt_pkg::out_t got);
            vpt_pkg::out_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.status == vpt_pkg::ST_SAT) sat_seen++;
            if (e.status == vpt_pkg::ST_WZERO) wzero_seen++;
            if (got.out_x !== e.out_x || got.out_y !== e.out_y ||
                got.out_z !== e.out_z || got.status !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                             e.out_x, e.out_y, e.out_z, e.status,
                             got.out_x, got.out_y, got.out_z, got.status);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    vpt_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    vpt_pkg::out_t out_data;
    logic cfg_we = 0;
    logic [vpt_pkg::IDX_W-1:0] cfg_index = '0;
    logic [vpt_pkg::REG_W-1:0] cfg_data = '0;

    vertex_scoreboard sb;
    int cycles = 0;
    int sent = 0;
    int ready_mode = 0;
    int stall_left = 0;

    vertex_projection_transform dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: check accepted results, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        if ($urandom_range(0, 199) == 0)
            ready_mode = $urandom_range(0, 2);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 0;
        end else if (ready_mode == 0) begin
            out_ready <= 1;
        end else begin
            if ($urandom_range(0, 99) == 0)
                stall_left = $urandom_range(10, 80);
            out_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return ($urandom_range(0, 1) ? -1 : 1) *
                      int'(($urandom_range(0, 15) << vpt_pkg::FRAC_BITS)
                           + $urandom_range(0, 65535));
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'($signed($urandom_range(0, 4)) - 2);
            default: return $urandom_range(0, 3) << vpt_pkg::FRAC_BITS;
        endcase
    endfunction

    function automatic int rand_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 29) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // Called at a rising edge; returns at the edge where the item was accepted.
    task automatic send_point(vpt_pkg::in_t d, int gap);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= d;
        do @(posedge clk); while (!in_ready);
        sb.note_point(d);
        sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic load_matrix(logic [31:0] e [16]);
        for (int k = 0; k < vpt_pkg::NUM_REGS; k++) begin
            cfg_we <= 1;
            cfg_index <= k[vpt_pkg::IDX_W-1:0];
            cfg_data <= {e[2*k+1], e[2*k]};
            sb.set_reg(k, {e[2*k+1], e[2*k]});
            @(posedge clk);
        end
        cfg_we <= 0;
    endtask

    function automatic vpt_pkg::in_t make_point(logic op, logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z);
        vpt_pkg::in_t d;
        d.op = op;
        d.in_x = x;
        d.in_y = y;
        d.in_z = z;
        return d;
    endfunction

    initial begin
        logic [31:0] m [16];
        vpt_pkg::in_t d;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Identity matrix: extremes pass through, projective divides by one.
        send_point(make_point(vpt_pkg::OP_AFFINE, 0, 0, 0), 0);
        send_point(make_point(vpt_pkg::OP_AFFINE, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF), 0);
        send_point(make_point(vpt_pkg::OP_PROJ, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h0000_0001), 1);
        send_point(make_point(vpt_pkg::OP_PROJ, 32'h0001_8000, 32'hFFFE_8000, 0), 0);
        wait_idle();

        // w from x alone: zero w, negative w, tiny w, and saturation by scaling.
        for (int i = 0; i < 16; i++) m[i] = 0;
        m[0] = 32'h0002_0000; m[5] = 32'hFFFF_0000; m[10] = 32'h0001_0000;
        m[3] = 32'h0001_0000; m[12] = 32'h0000_8000; m[14] = 32'h8000_0000;
        load_matrix(m);
        send_point(make_point(vpt_pkg::OP_PROJ, 0, 32'h0001_0000, 32'h0002_0000), 0);
        send_point(make_point(vpt_pkg::OP_PROJ, 32'hFFFF_0000, 32'h0003_0000,
                              32'h7FFF_FFFF), 0);
        send_point(make_point(vpt_pkg::OP_PROJ, 32'h0000_0001, 32'h0001_0000,
                              32'h0001_0000), 0);
        send_point(make_point(vpt_pkg::OP_PROJ, 32'hFFFF_FFFF, 32'h8000_0000, 0), 2);
        send_point(make_point(vpt_pkg::OP_AFFINE, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h8000_0000), 0);
        send_point(make_point(vpt_pkg::OP_AFFINE, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF), 0);
        send_point(make_point(vpt_pkg::OP_PROJ, 32'h0040_0000, 32'h0000_0010,
                              32'hFFF0_0000), 0);
        wait_idle();

        // Extreme matrices, then random ones.
        for (int phase = 0; phase < 12; phase++) begin
            for (int i = 0; i < 16; i++) begin
                case (phase)
                    0: m[i] = 32'h7FFF_FFFF;
                    1: m[i] = 32'h8000_0000;
                    2: m[i] = 0;
                    default: m[i] = rand_value();
                endcase
            end
            // In phase 5, clear row 3 so that every projective point has w zero.
            if (phase == 5) begin
                m[3] = 0; m[7] = 0; m[11] = 0; m[15] = 0;
            end
            load_matrix(m);
            repeat (phase < 3 ? 30 : 95) begin
                d = make_point(1'($urandom_range(0, 1)), rand_value(), rand_value(),
                               rand_value());
                send_point(d, rand_gap());
            end
            wait_idle();
        end

        $display("sent %0d points, checked %0d results over 14 matrix settings", sent,
                 sb.checked);
        $display("saturated results %0d, zero-w results %0d", sb.sat_seen, sb.wzero_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
